// File: hw/rtl/gedge_pkg.sv
package gedge_pkg;

    localparam int unsigned PIX_W        = 8;
    localparam int unsigned IN_TDATA_W   = 3 * PIX_W;
    localparam int unsigned WIDTH_REG_W  = 11;
    localparam int unsigned HEIGHT_REG_W = 12;
    localparam int unsigned CFG_DATA_W   = 12;
    localparam int unsigned CFG_INDEX_W  = 2;

    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned MAX_HEIGHT   = 4095;

    // gray = (30r + 59g + 11b) / 100 via reciprocal, exact for sums below 43690
    localparam int unsigned GRAY_SUM_W   = 15;
    localparam int unsigned COEF_RED     = 30;
    localparam int unsigned COEF_GREEN   = 59;
    localparam int unsigned COEF_BLUE    = 11;
    localparam int unsigned RECIP_W      = 16;
    localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
    localparam int unsigned RECIP_SHIFT  = 22;
    localparam int unsigned PROD_W       = GRAY_SUM_W + RECIP_W;

    localparam int unsigned SUM3_W       = PIX_W + 2;
    localparam int unsigned EDGE_SUM_W   = SUM3_W + 1;

    localparam int unsigned FIFO_DEPTH   = 8;
    localparam int unsigned FIFO_AW      = 3;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_EDGE_MODE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_pix edge_value;
        logic last_col;
    } t_edge_ent;

endpackage

// File: hw/rtl/gradient_edge_detector.sv
// channel   | dir | tdata (lsb up)            | tlast   | tuser
// s_axis    | in  | red, green, blue          | -       | -
// m_axis    | out | edge_value                | row_end | last_of_run
// cfg       | in  | i_cfg_wr_en, i_cfg_index, i_cfg_data (no read-back)
//
// one pixel per cycle while s_axis_tready is high; a result passes the stage 1 and stage 2 registers and the fifo
// a last-column pixel gives two results, so output carries one extra result per row
// line stores live in one 16-bit wide ram, read on accept, written in the next cycle
// s_axis_tready drops when the 8-entry result fifo plus in-flight pixels is full
// synchronous reset clears counters, window, fifo pointers, valid flags and config registers; line ram is not cleared
module gradient_edge_detector #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [gedge_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // red, green, blue
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [gedge_pkg::PIX_W-1:0]           m_axis_tdata,   // edge_value
    output logic                                  m_axis_tlast,
    output logic [0:0]                            m_axis_tuser,   // last_of_run
    input  logic                                  i_cfg_wr_en,
    input  logic [gedge_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [gedge_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = (XW + 1 > gedge_pkg::WIDTH_REG_W) ? XW + 1
                                                                   : gedge_pkg::WIDTH_REG_W;
    localparam int unsigned PW = gedge_pkg::PIX_W;
    localparam int unsigned HW = gedge_pkg::HEIGHT_REG_W;
    localparam int unsigned SW = gedge_pkg::SUM3_W;
    localparam int unsigned AW = gedge_pkg::FIFO_AW;

    // configuration
    logic [gedge_pkg::WIDTH_REG_W-1:0] r_line_width;
    logic [HW-1:0]                     r_frame_height;
    logic                              r_edge_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= gedge_pkg::WIDTH_REG_W'(640);
            r_frame_height <= HW'(480);
            r_edge_mode    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (gedge_pkg::t_cfg_idx'(i_cfg_index))
                gedge_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data[gedge_pkg::WIDTH_REG_W-1:0];
                end
                gedge_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[HW-1:0];
                end
                gedge_pkg::CFG_EDGE_MODE: begin
                    r_edge_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective dimensions
    logic [CW-1:0] width_ext;
    logic [CW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    always_comb begin
        width_ext = CW'(r_line_width);
        if (width_ext < CW'(gedge_pkg::MIN_DIM)) begin
            width_eff = CW'(gedge_pkg::MIN_DIM);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (r_frame_height < HW'(gedge_pkg::MIN_DIM)) begin
            height_eff = HW'(gedge_pkg::MIN_DIM);
        end else begin
            height_eff = r_frame_height;
        end
    end

    // position counters
    logic [XW-1:0] r_col;
    logic [HW-1:0] r_row;
    logic          last_col;
    logic          last_row;
    logic          in_xact;

    assign last_col = CW'(r_col) >= (width_eff - CW'(1));
    assign last_row = r_row >= (height_eff - HW'(1));
    assign in_xact  = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xact) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + HW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    // stage 1: weighted colour sum, line ram read
    logic [gedge_pkg::GRAY_SUM_W-1:0] gray_sum;
    logic                             r_s1_vld;
    logic [gedge_pkg::GRAY_SUM_W-1:0] r_s1_sum;
    logic [XW-1:0]                    r_s1_addr;
    logic                             r_s1_emit;
    logic                             r_s1_zero;
    logic                             r_s1_last;

    assign gray_sum =
        gedge_pkg::GRAY_SUM_W'(gedge_pkg::COEF_RED)   * gedge_pkg::GRAY_SUM_W'(s_axis_tdata[PW-1:0])
      + gedge_pkg::GRAY_SUM_W'(gedge_pkg::COEF_GREEN) * gedge_pkg::GRAY_SUM_W'(s_axis_tdata[2*PW-1:PW])
      + gedge_pkg::GRAY_SUM_W'(gedge_pkg::COEF_BLUE)  * gedge_pkg::GRAY_SUM_W'(s_axis_tdata[3*PW-1:2*PW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_xact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_s1_sum  <= gray_sum;
            r_s1_addr <= r_col;
            r_s1_emit <= (r_col != '0) && (r_row != '0);
            r_s1_zero <= (r_col == XW'(1)) || (r_row == HW'(1));
            r_s1_last <= last_col;
        end
    end

    // line ram: older line in the upper byte, newer line in the lower byte
    logic [2*PW-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_line_rd;
    logic [gedge_pkg::PROD_W-1:0] gray_prod;
    gedge_pkg::t_pix              gray;

    assign gray_prod = gedge_pkg::PROD_W'(r_s1_sum) * gedge_pkg::PROD_W'(gedge_pkg::RECIP_100);
    assign gray      = gray_prod[gedge_pkg::RECIP_SHIFT +: PW];

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_line_rd <= r_line_mem[r_col];
        end
        if (r_s1_vld) begin
            r_line_mem[r_s1_addr] <= {r_line_rd[PW-1:0], gray};
        end
    end

    // stage 2: window shift
    gedge_pkg::t_pix r_win [3][3];
    logic            r_s2_vld;
    logic            r_s2_emit;
    logic            r_s2_zero;
    logic            r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            r_s2_vld <= r_s1_vld;
            if (r_s1_vld) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= r_line_rd[2*PW-1:PW];
                r_win[1][2] <= r_line_rd[PW-1:0];
                r_win[2][2] <= gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_emit <= r_s1_emit;
            r_s2_zero <= r_s1_zero;
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3: gradient magnitude
    logic [SW-1:0]                    top_sum, bot_sum, lft_sum, rgt_sum;
    logic [SW-1:0]                    gx_abs, gy_abs;
    logic [gedge_pkg::EDGE_SUM_W-1:0] mag;
    gedge_pkg::t_pix                  edge_sat;

    function automatic logic [SW-1:0] wsum3(input gedge_pkg::t_pix a, input gedge_pkg::t_pix b,
                                            input gedge_pkg::t_pix c, input logic dbl);
        logic [SW-1:0] mid;
        mid = dbl ? {1'b0, b, 1'b0} : SW'(b);
        return SW'(a) + mid + SW'(c);
    endfunction

    always_comb begin
        top_sum = wsum3(r_win[0][0], r_win[0][1], r_win[0][2], r_edge_mode);
        bot_sum = wsum3(r_win[2][0], r_win[2][1], r_win[2][2], r_edge_mode);
        lft_sum = wsum3(r_win[0][0], r_win[1][0], r_win[2][0], r_edge_mode);
        rgt_sum = wsum3(r_win[0][2], r_win[1][2], r_win[2][2], r_edge_mode);
        gx_abs  = (bot_sum >= top_sum) ? bot_sum - top_sum : top_sum - bot_sum;
        gy_abs  = (rgt_sum >= lft_sum) ? rgt_sum - lft_sum : lft_sum - rgt_sum;
        mag     = gedge_pkg::EDGE_SUM_W'(gx_abs) + gedge_pkg::EDGE_SUM_W'(gy_abs);
        if (r_s2_zero) begin
            edge_sat = '0;
        end else if (mag > gedge_pkg::EDGE_SUM_W'(255)) begin
            edge_sat = '1;
        end else begin
            edge_sat = mag[PW-1:0];
        end
    end

    // result fifo, one entry per pixel that gives results
    gedge_pkg::t_edge_ent r_fifo [gedge_pkg::FIFO_DEPTH];
    logic [AW-1:0]        r_wr_ptr;
    logic [AW-1:0]        r_rd_ptr;
    logic [AW:0]          r_fifo_cnt;
    logic                 r_second;
    gedge_pkg::t_edge_ent head;
    logic                 push;
    logic                 pop;
    logic                 out_xact;
    logic [AW+1:0]        credit_use;

    assign head       = r_fifo[r_rd_ptr];
    assign push       = r_s2_vld && r_s2_emit;
    assign out_xact   = m_axis_tvalid && m_axis_tready;
    assign pop        = out_xact && (!head.last_col || r_second);
    assign credit_use = (AW + 2)'(r_fifo_cnt) + (AW + 2)'(r_s1_vld) + (AW + 2)'(r_s2_vld);

    assign s_axis_tready = credit_use < (AW + 2)'(gedge_pkg::FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{edge_value: edge_sat, last_col: r_s2_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_second   <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + (AW + 1)'(push) - (AW + 1)'(pop);
            if (out_xact) begin
                r_second <= head.last_col && !r_second;
            end
        end
    end

    // second result of a last-column pixel is the right border zero
    assign m_axis_tvalid   = r_fifo_cnt != '0;
    assign m_axis_tdata    = r_second ? '0 : head.edge_value;
    assign m_axis_tlast    = r_second;
    assign m_axis_tuser[0] = r_second || !head.last_col;

endmodule
